@@ sv/exchange_sort_swap_counter_assert.svh @@
// Assertion macros for the exchange sort block.
`ifndef EXCHANGE_SORT_SWAP_COUNTER_ASSERT_SVH
`define EXCHANGE_SORT_SWAP_COUNTER_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define ESS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ess assertion failed: same-cycle check");

// Condition holds in the cycle after the trigger.
`define ESS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ess assertion failed: next-cycle check");

`endif

@@ sv/ess_pkg.sv @@
`default_nettype none

package ess_pkg;

    localparam int ESS_MAX_ITEMS   = 32;
    localparam int ESS_QUEUE_DEPTH = 4;
    localparam int ESS_VALUE_W     = 32;
    localparam int ESS_SWAP_W      = 9;
    localparam logic [ESS_SWAP_W-1:0] ESS_SWAP_MAX = '1;

    typedef logic signed [ESS_VALUE_W-1:0] ess_value_t;
    typedef logic [ESS_SWAP_W-1:0]         ess_swap_t;

    // Classification of one queued word
    typedef struct packed {
        logic store;  // write value into its slot
        logic last;   // closes the set
        logic ovf;    // some word of this set was dropped
    } ess_ctl_t;

endpackage

`default_nettype wire

@@ sv/ess_queue.sv @@
`default_nettype none

module ess_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      pop_data,
    output logic              empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] fill_reg;

    assign full     = (fill_reg == CW'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/ess_front.sv @@
`default_nettype none

module ess_front #(
    parameter int MAX_ITEMS = ess_pkg::ESS_MAX_ITEMS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire ess_pkg::ess_value_t                  s_value,
    input  wire logic                                 s_last,
    input  wire logic                                 q_full,
    output logic                                      push,
    output ess_pkg::ess_value_t                       push_value,
    output logic [$clog2(MAX_ITEMS)-1:0]              push_slot,
    output logic [$clog2(MAX_ITEMS+1)-1:0]            push_count,
    output ess_pkg::ess_ctl_t                         push_ctl
);

    import ess_pkg::*;

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             accept;
    logic             store_full;

    assign s_ready    = !q_full;
    assign accept     = s_valid && s_ready;
    assign store_full = (count_reg == CNT_W'(MAX_ITEMS));

    // Dropped words that do not close the set never enter the queue
    assign push           = accept && (!store_full || s_last);
    assign push_value     = s_value;
    assign push_slot      = count_reg[IDX_W-1:0];
    assign push_count     = store_full ? count_reg : count_reg + 1'b1;
    assign push_ctl.store = !store_full;
    assign push_ctl.last  = s_last;
    assign push_ctl.ovf   = ovf_reg || store_full;

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept) begin
            if (s_last) begin
                count_next = '0;
                ovf_next   = 1'b0;
            end else if (store_full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/ess_back.sv @@
`default_nettype none

module ess_back #(
    parameter int MAX_ITEMS = ess_pkg::ESS_MAX_ITEMS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 q_empty,
    output logic                                      q_pop,
    input  wire ess_pkg::ess_value_t                  q_value,
    input  wire logic [$clog2(MAX_ITEMS)-1:0]         q_slot,
    input  wire logic [$clog2(MAX_ITEMS+1)-1:0]       q_count,
    input  wire ess_pkg::ess_ctl_t                    q_ctl,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output ess_pkg::ess_value_t                       m_sorted_value,
    output ess_pkg::ess_swap_t                        m_swap_count,
    output logic                                      m_overflowed,
    output logic                                      m_last_out
);

    import ess_pkg::*;

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic [2:0] {
        S_FILL,
        S_RDI,
        S_LDI,
        S_CMP,
        S_WRI,
        S_ORD,
        S_OLD,
        S_OWAIT
    } state_t;

    ess_value_t element_store [MAX_ITEMS];
    ess_value_t rdata_reg;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] n_reg, n_next;
    ess_value_t       cur_reg, cur_next;
    ess_swap_t        swap_reg, swap_next;
    logic             ovf_reg, ovf_next;
    logic             mv_reg, mv_next;
    ess_value_t       mdata_reg, mdata_next;
    logic             mlast_reg, mlast_next;

    logic             we;
    logic [IDX_W-1:0] waddr;
    ess_value_t       wdata;
    logic [IDX_W-1:0] raddr;

    assign m_valid        = mv_reg;
    assign m_sorted_value = mdata_reg;
    assign m_swap_count   = swap_reg;
    assign m_overflowed   = ovf_reg;
    assign m_last_out     = mlast_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            element_store[waddr] <= wdata;
        end
        rdata_reg <= element_store[raddr];
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        cur_next   = cur_reg;
        swap_next  = swap_reg;
        ovf_next   = ovf_reg;
        mv_next    = mv_reg;
        mdata_next = mdata_reg;
        mlast_next = mlast_reg;
        we         = 1'b0;
        waddr      = q_slot;
        wdata      = q_value;
        raddr      = i_reg;
        q_pop      = 1'b0;
        case (state_reg)
            S_FILL: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    we    = q_ctl.store;
                    if (q_ctl.last) begin
                        n_next     = q_count;
                        ovf_next   = q_ctl.ovf;
                        swap_next  = '0;
                        i_next     = '0;
                        k_next     = '0;
                        state_next = (q_count >= CNT_W'(2)) ? S_RDI : S_ORD;
                    end
                end
            end
            S_RDI: begin
                raddr      = i_reg;
                state_next = S_LDI;
            end
            S_LDI: begin
                cur_next   = rdata_reg;
                raddr      = i_reg + 1'b1;
                j_next     = i_reg + 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                // Hold a[i] in cur; exchange with a[j] when a[i] is larger
                if (cur_reg > rdata_reg) begin
                    we       = 1'b1;
                    waddr    = j_reg;
                    wdata    = cur_reg;
                    cur_next = rdata_reg;
                    if (swap_reg != ESS_SWAP_MAX) begin
                        swap_next = swap_reg + 1'b1;
                    end
                end
                raddr  = j_reg + 1'b1;
                j_next = j_reg + 1'b1;
                if (CNT_W'(j_reg) + CNT_W'(1) == n_reg) begin
                    state_next = S_WRI;
                end
            end
            S_WRI: begin
                we     = 1'b1;
                waddr  = i_reg;
                wdata  = cur_reg;
                i_next = i_reg + 1'b1;
                if (CNT_W'(i_reg) + CNT_W'(2) < n_reg) begin
                    state_next = S_RDI;
                end else begin
                    k_next     = '0;
                    state_next = S_ORD;
                end
            end
            S_ORD: begin
                raddr      = k_reg;
                state_next = S_OLD;
            end
            S_OLD: begin
                mv_next    = 1'b1;
                mdata_next = rdata_reg;
                mlast_next = (CNT_W'(k_reg) + CNT_W'(1) == n_reg);
                state_next = S_OWAIT;
            end
            S_OWAIT: begin
                if (m_ready) begin
                    mv_next = 1'b0;
                    if (mlast_reg) begin
                        state_next = S_FILL;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_ORD;
                    end
                end
            end
            default: begin
                state_next = S_FILL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_FILL;
            mv_reg    <= 1'b0;
            swap_reg  <= '0;
            ovf_reg   <= 1'b0;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            mlast_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            swap_reg  <= swap_next;
            ovf_reg   <= ovf_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            mlast_reg <= mlast_next;
        end
        cur_reg   <= cur_next;
        mdata_reg <= mdata_next;
    end

endmodule

`default_nettype wire

@@ sv/exchange_sort_swap_counter.sv @@
// Channel  | Ports                                                  | Word
// ---------+--------------------------------------------------------+-------------------------
// input    | s_valid s_ready s_value s_last                         | one element, last closes
// result   | m_valid m_ready m_sorted_value m_swap_count            | one sorted element
//          | m_overflowed m_last_out                                |
//
// Input words are taken one per cycle while the front queue has room, also while a set sorts.
// A set of n stored elements sorts with one compare a cycle through the single read port of
// the element memory; a result is read out only once the result before it has been taken.
// Reset is synchronous, active low; the element memory needs no clearing.
// A stalled result holds the back end; the front keeps filling the queue until it is full.
`default_nettype none

module exchange_sort_swap_counter #(
    parameter int MAX_ITEMS   = ess_pkg::ESS_MAX_ITEMS,
    parameter int QUEUE_DEPTH = ess_pkg::ESS_QUEUE_DEPTH
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ess_pkg::ess_value_t s_value,
    input  wire logic                s_last,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ess_pkg::ess_value_t      m_sorted_value,
    output ess_pkg::ess_swap_t       m_swap_count,
    output logic                     m_overflowed,
    output logic                     m_last_out
);

    import ess_pkg::*;

    `include "exchange_sort_swap_counter_assert.svh"

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int QW    = ESS_VALUE_W + IDX_W + CNT_W + $bits(ess_ctl_t);

    logic             q_push, q_full, q_pop, q_empty;
    ess_value_t       push_value, pop_value;
    logic [IDX_W-1:0] push_slot, pop_slot;
    logic [CNT_W-1:0] push_count, pop_count;
    ess_ctl_t         push_ctl, pop_ctl;
    logic [QW-1:0]    push_data, pop_data;

    assign push_data = {push_value, push_slot, push_count, push_ctl};
    assign {pop_value, pop_slot, pop_count, pop_ctl} = pop_data;

    ess_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .s_last     (s_last),
        .q_full     (q_full),
        .push       (q_push),
        .push_value (push_value),
        .push_slot  (push_slot),
        .push_count (push_count),
        .push_ctl   (push_ctl)
    );

    ess_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    ess_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .q_value        (pop_value),
        .q_slot         (pop_slot),
        .q_count        (pop_count),
        .q_ctl          (pop_ctl),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_swap_count   (m_swap_count),
        .m_overflowed   (m_overflowed),
        .m_last_out     (m_last_out)
    );

    `ESS_ASSERT_SAME(a_no_push_full, aclk, aresetn, q_push, !q_full)
    `ESS_ASSERT_SAME(a_no_pop_empty, aclk, aresetn, q_pop, !q_empty)
    `ESS_ASSERT_NEXT(a_result_gap, aclk, aresetn, m_valid && m_ready, !m_valid)

endmodule

`default_nettype wire
